FILE: design/crx_pkg.sv
// Package for the character range expander: constants, payload types and controller links.
`timescale 1ns / 1ps

package crx_pkg;

  // Character codes
  localparam logic [7:0] DashCode  = 8'h2D;
  localparam logic [7:0] NulCode   = 8'h00;
  localparam logic [7:0] UpperLo   = 8'h41;  // 'A'
  localparam logic [7:0] UpperHi   = 8'h5A;  // 'Z'
  localparam logic [7:0] LowerLo   = 8'h61;  // 'a'
  localparam logic [7:0] LowerHi   = 8'h7A;  // 'z'
  localparam logic [7:0] DigitLo   = 8'h30;  // '0'
  localparam logic [7:0] DigitHi   = 8'h39;  // '9'

  // Input transaction payload
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  // Output transaction payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       is_terminator;
  } out_t;

  // Source of the character loaded into the output register
  typedef enum logic [1:0] {
    SEL_START = 2'd0,
    SEL_DASH  = 2'd1,
    SEL_LAST  = 2'd2,
    SEL_SCAN  = 2'd3
  } out_sel_e;

  // Emission plan decoded for one accepted item
  typedef struct packed {
    logic emit_start;
    logic emit_dash;
    logic emit_last;
    logic scan;
  } plan_t;

  // Controller to datapath
  typedef struct packed {
    logic     accept;
    logic     load_out;
    out_sel_e sel;
    logic     last;
    logic     scan_step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    plan_t plan;
    logic  out_free;
    logic  k_alnum;
    logic  k_at_end;
  } status_t;

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = ((c >= UpperLo) && (c <= UpperHi)) ||
               ((c >= LowerLo) && (c <= LowerHi)) ||
               ((c >= DigitLo) && (c <= DigitHi));
  endfunction

endpackage

FILE: design/crx_datapath.sv
// Datapath of the character range expander: pending state, scan counter, output register.
`timescale 1ns / 1ps

module crx_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  crx_pkg::in_t     in_i,
  input  crx_pkg::cmd_t    cmd_i,
  output crx_pkg::status_t status_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output crx_pkg::out_t    out_o
);
  import crx_pkg::*;

  logic [7:0] range_start_q, range_start_d;
  logic       dash_q, dash_d;
  logic [7:0] held_start_q;
  logic [7:0] last_char_q;
  logic       term_q;
  logic [7:0] k_q;
  logic       out_valid_q;
  out_t       out_q;
  plan_t      plan;
  logic       start_nz;
  logic       dash_store;
  logic [7:0] sel_char;

  // Decode the plan and the next pending state for the offered item
  always_comb begin
    plan          = '0;
    range_start_d = range_start_q;
    dash_d        = dash_q;
    start_nz      = (range_start_q != NulCode);
    dash_store    = start_nz && (in_i.text_byte == DashCode);
    if (in_i.end_of_text) begin
      plan.emit_start = start_nz;
      plan.emit_dash  = dash_q;
      plan.emit_last  = 1'b1;
      range_start_d   = NulCode;
      dash_d          = 1'b0;
    end else if (dash_store) begin
      dash_d = 1'b1;
    end else if (is_alnum(in_i.text_byte)) begin
      if (dash_q) begin
        if (in_i.text_byte < range_start_q) begin
          // descending pair is copied literally
          plan.emit_start = 1'b1;
          plan.emit_dash  = 1'b1;
          plan.emit_last  = 1'b1;
        end else begin
          plan.scan = 1'b1;
        end
        range_start_d = NulCode;
        dash_d        = 1'b0;
      end else begin
        plan.emit_start = start_nz;
        range_start_d   = in_i.text_byte;
      end
    end else begin
      plan.emit_start = start_nz;
      plan.emit_dash  = dash_q;
      plan.emit_last  = 1'b1;
      range_start_d   = NulCode;
      dash_d          = 1'b0;
    end
  end

  // Pending state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_start_q <= NulCode;
      dash_q        <= 1'b0;
    end else if (cmd_i.accept) begin
      range_start_q <= range_start_d;
      dash_q        <= dash_d;
    end
  end

  // Per-item working registers and scan counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      held_start_q <= range_start_q;
      last_char_q  <= in_i.end_of_text ? NulCode : in_i.text_byte;
      term_q       <= in_i.end_of_text;
      k_q          <= range_start_q;
    end else if (cmd_i.scan_step) begin
      k_q <= k_q + 8'd1;
    end
  end

  // Output character selection
  always_comb begin
    unique case (cmd_i.sel)
      SEL_START: sel_char = held_start_q;
      SEL_DASH:  sel_char = DashCode;
      SEL_LAST:  sel_char = last_char_q;
      SEL_SCAN:  sel_char = k_q;
      default:   sel_char = NulCode;
    endcase
  end

  // Output register, freed when the receiver takes the transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.out_byte      <= sel_char;
      out_q.run_last      <= cmd_i.last;
      out_q.is_terminator <= (cmd_i.sel == SEL_LAST) && term_q;
    end
  end

  assign status_o.plan     = plan;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.k_alnum  = is_alnum(k_q);
  assign status_o.k_at_end = (k_q == last_char_q);
  assign out_valid_o       = out_valid_q;
  assign out_o             = out_q;

endmodule

FILE: design/crx_controller.sv
// Controller of the character range expander: sequences the results of one item.
`timescale 1ns / 1ps

module crx_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  crx_pkg::status_t status_i,
  output crx_pkg::cmd_t    cmd_o
);
  import crx_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_DASH  = 5'b00100,
    S_LAST  = 5'b01000,
    S_SCAN  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  plan_t  plan_q, plan_d;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    plan_d        = plan_q;
    cmd_o         = '0;
    cmd_o.sel     = SEL_START;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          plan_d       = status_i.plan;
          if (status_i.plan.emit_start)     state_d = S_START;
          else if (status_i.plan.emit_dash) state_d = S_DASH;
          else if (status_i.plan.emit_last) state_d = S_LAST;
          else if (status_i.plan.scan)      state_d = S_SCAN;
        end
      end
      S_START: begin
        cmd_o.sel  = SEL_START;
        cmd_o.last = !plan_q.emit_dash && !plan_q.emit_last;
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (plan_q.emit_dash)      state_d = S_DASH;
          else if (plan_q.emit_last) state_d = S_LAST;
          else                       state_d = S_IDLE;
        end
      end
      S_DASH: begin
        cmd_o.sel  = SEL_DASH;
        cmd_o.last = !plan_q.emit_last;
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = plan_q.emit_last ? S_LAST : S_IDLE;
        end
      end
      S_LAST: begin
        cmd_o.sel  = SEL_LAST;
        cmd_o.last = 1'b1;
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_SCAN: begin
        // one code per cycle unless output stalls; non-alnum codes are skipped
        cmd_o.sel  = SEL_SCAN;
        cmd_o.last = status_i.k_at_end;
        if (!status_i.k_alnum) begin
          cmd_o.scan_step = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (status_i.k_at_end) state_d = S_IDLE;
          else                   cmd_o.scan_step = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      plan_q  <= '0;
    end else begin
      state_q <= state_d;
      plan_q  <= plan_d;
    end
  end

endmodule

FILE: design/char_range_expander.sv
// Top level of the character range expander.
//
// Input channel (in_valid_i / in_ready_o / in_i) carries one text byte per
// transaction, or an end marker. Output channel (out_valid_o / out_ready_i /
// out_o) carries one expanded character per transaction; run_last flags the
// final result of an input item and is_terminator flags the closing NUL.
// Shorthand such as a-z or 0-9 is expanded to every letter or digit in the
// run; other bytes pass through, flushing any pending start and dash.
// After acceptance the first emit state loads the first result once the
// output register is free. Literal output gives one result per cycle and a
// range scans one code per cycle from its start to its end, both while the
// output register is free. A new item is accepted once the previous item's
// last result sits in the output register; for items that only store a
// start or a dash the sequencer stays idle. When the receiver stalls, the
// output register holds its transaction and the sequencer waits. Reset
// clears the pending start and dash and empties the output register.
`timescale 1ns / 1ps

module char_range_expander (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  crx_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output crx_pkg::out_t out_o
);
  import crx_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  crx_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // State, scan counter and output register
  crx_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

FILE: design/crx_checker.sv
// Port-level checker for the character range expander, bound to the top level.
`timescale 1ns / 1ps

module crx_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input crx_pkg::in_t  in_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input crx_pkg::out_t out_o
);
  import crx_pkg::*;

  // A stalled output transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled output transaction changed");

  // The terminator is a NUL and closes its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.is_terminator |-> out_o.run_last && (out_o.out_byte == NulCode))
    else $error("bad terminator transaction");

  // An end item always produces results, so input is held off next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_i.end_of_text |=> !in_ready_o)
    else $error("end item produced no results");

  // No new item while the current item still has results to come
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.run_last |-> !in_ready_o)
    else $error("input accepted mid-item");

endmodule

bind char_range_expander crx_checker u_crx_checker (.*);
